>>> sv/olg_pkg.sv
// ----------------------------------------------------------------------------
// olg_pkg: shared types and constants of the occupancy log-odds grid update
// Coordinate and log-odds widths, the probability edge clamp and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package olg_pkg;

  // Signed grid coordinate width and cell address width (row, then column)
  localparam int COORD_BITS        = 8;
  localparam int ADDR_BITS         = 2 * COORD_BITS;
  localparam int CELL_COUNT        = 1 << ADDR_BITS;

  // Log-odds word: signed, LOGODDS_FRAC_BITS fraction bits
  localparam int LOGODDS_FRAC_BITS = 10;
  localparam int LO_BITS           = 14;
  localparam int CEIL_BITS         = 13;
  localparam int SUM_BITS          = LO_BITS + 1;

  // ln(999) in units of 2^-20, rounded to the log-odds fraction
  localparam longint LN999_Q20     = 64'sd7242257;
  localparam int EDGE              = int'((LN999_Q20 + (64'sd1 << (19 - LOGODDS_FRAC_BITS)))
                                          >>> (20 - LOGODDS_FRAC_BITS));

  // Configuration register indexes
  localparam int CFG_IDX_BITS      = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CEILING = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [ADDR_BITS-1:0]  addr_t;
  typedef logic signed [LO_BITS-1:0]    lo_t;
  typedef logic        [CEIL_BITS-1:0]  ceil_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  // Clamp a log-odds word to +/-EDGE
  function automatic lo_t clamp_edge(lo_t v);
    lo_t r;
    r = v;
    if (v > lo_t'(EDGE)) begin
      r = lo_t'(EDGE);
    end else if (v < -lo_t'(EDGE)) begin
      r = -lo_t'(EDGE);
    end
    return r;
  endfunction

endpackage

>>> sv/occupancy_logodds_grid_update.sv
// ----------------------------------------------------------------------------
// occupancy_logodds_grid_update: log-odds occupancy grid cell update
// Read-modify-write of one grid cell per request with a seen-bit memory, a
// log-odds memory and a running bounding box of the seen cells.
// ----------------------------------------------------------------------------
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+------------------
//   in       | cell_row, cell_col, meas_logodds             | in_valid/in_ready
//   out      | new_logodds, first_visit, row/col min/max    | out_valid/out_ready
//   cfg      | cfg_index, cfg_wdata                         | cfg_we, no wait
//
// One request per cycle sustained while the output is not stalled. A request
// reads both memories at the edge it is accepted, is updated and written back on
// retiring, and lands in the output register. A request to the cell the previous
// request is writing takes the forwarded value; the single memory write port per
// store sets the rate. After reset a clearing pass zeroes the 65536 seen bits, one
// per cycle, and in_ready stays low until it ends; configuration writes go
// through. A stalled output holds the update stage, which then holds in_ready low.
//
module occupancy_logodds_grid_update (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // measurement requests
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [olg_pkg::COORD_BITS-1:0] in_cell_row,
  input  logic signed [olg_pkg::COORD_BITS-1:0] in_cell_col,
  input  logic signed [olg_pkg::LO_BITS-1:0]    in_meas_logodds,
  // updated cells
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [olg_pkg::LO_BITS-1:0]    out_new_logodds,
  output logic                                  out_first_visit,
  output logic signed [olg_pkg::COORD_BITS-1:0] out_row_min,
  output logic signed [olg_pkg::COORD_BITS-1:0] out_row_max,
  output logic signed [olg_pkg::COORD_BITS-1:0] out_col_min,
  output logic signed [olg_pkg::COORD_BITS-1:0] out_col_max,
  // configuration
  input  logic                                  cfg_we,
  input  logic [olg_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [olg_pkg::LO_BITS-1:0]           cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  olg_pkg::lo_t   floor_r;
  olg_pkg::ceil_t ceiling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r   <= olg_pkg::lo_t'(-4096);
      ceiling_r <= olg_pkg::ceil_t'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        olg_pkg::REG_FLOOR:   floor_r   <= olg_pkg::lo_t'(cfg_wdata);
        olg_pkg::REG_CEILING: ceiling_r <= cfg_wdata[olg_pkg::CEIL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Seen-bit clearing pass after reset
  // --------------------------------------------------------------------------
  logic           clr_busy_r, clr_busy_nxt;
  olg_pkg::addr_t clr_addr_r, clr_addr_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + olg_pkg::addr_t'(1);
      // stop after the last entry
      if (clr_addr_r == '1) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_fire;
  logic in_fire;

  // the update stage retires into the output register when it is free or draining
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_fire);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Request address and update-stage payload
  // --------------------------------------------------------------------------
  olg_pkg::addr_t  in_addr;
  olg_pkg::addr_t  s1_addr_r;
  olg_pkg::coord_t s1_row_r;
  olg_pkg::coord_t s1_col_r;
  olg_pkg::lo_t    s1_meas_r;

  assign in_addr = {in_cell_row, in_cell_col};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r <= in_addr;
      s1_row_r  <= in_cell_row;
      s1_col_r  <= in_cell_col;
      s1_meas_r <= in_meas_logodds;
    end
  end

  // --------------------------------------------------------------------------
  // Memories: seen bits (cleared after reset) and log-odds words
  // --------------------------------------------------------------------------
  logic           seen_mem [olg_pkg::CELL_COUNT];
  olg_pkg::lo_t   lo_mem   [olg_pkg::CELL_COUNT];
  logic           seen_rd_r;
  olg_pkg::lo_t   lo_rd_r;
  olg_pkg::lo_t   new_lo;
  logic           seen_we;
  olg_pkg::addr_t seen_waddr;
  logic           seen_wdata;

  // clearing pass owns the write port; no request is in flight meanwhile
  assign seen_we    = clr_busy_r || s1_fire;
  assign seen_waddr = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign seen_wdata = !clr_busy_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      seen_rd_r <= seen_mem[in_addr];
    end
    if (seen_we) begin
      seen_mem[seen_waddr] <= seen_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lo_rd_r <= lo_mem[in_addr];
    end
    if (s1_fire) begin
      lo_mem[s1_addr_r] <= new_lo;
    end
  end

  // Forward the word being written when the next request reads the same cell:
  // the memory returns the old contents on a read during write.
  logic         fwd_hit_r;
  olg_pkg::lo_t fwd_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_fire) begin
      fwd_hit_r <= s1_fire && (in_addr == s1_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_lo_r <= new_lo;
    end
  end

  // --------------------------------------------------------------------------
  // Update: clamp old and measured values, add, clamp to floor then ceiling
  // --------------------------------------------------------------------------
  logic          old_seen;
  olg_pkg::lo_t  old_lo;
  olg_pkg::sum_t sum_raw;
  olg_pkg::sum_t sum_lo;
  olg_pkg::sum_t sum_clamped;
  olg_pkg::sum_t floor_ext;
  olg_pkg::sum_t ceil_ext;

  assign old_seen  = fwd_hit_r || seen_rd_r;
  assign floor_ext = olg_pkg::sum_t'(floor_r);
  assign ceil_ext  = olg_pkg::sum_t'({1'b0, ceiling_r});

  always_comb begin
    // unseen cell counts as log-odds zero
    old_lo = '0;
    if (fwd_hit_r) begin
      old_lo = olg_pkg::clamp_edge(fwd_lo_r);
    end else if (seen_rd_r) begin
      old_lo = olg_pkg::clamp_edge(lo_rd_r);
    end
    sum_raw = olg_pkg::sum_t'(old_lo) + olg_pkg::sum_t'(olg_pkg::clamp_edge(s1_meas_r));
    sum_lo  = (sum_raw < floor_ext) ? floor_ext : sum_raw;
    // ceiling wins when floor sits above it
    sum_clamped = (sum_lo > ceil_ext) ? ceil_ext : sum_lo;
    new_lo  = sum_clamped[olg_pkg::LO_BITS-1:0];
  end

  // --------------------------------------------------------------------------
  // Bounding box of the seen cells
  // --------------------------------------------------------------------------
  logic            any_seen_r, any_seen_nxt;
  olg_pkg::coord_t row_min_r, row_max_r, col_min_r, col_max_r;
  olg_pkg::coord_t row_min_nxt, row_max_nxt, col_min_nxt, col_max_nxt;

  always_comb begin
    any_seen_nxt = any_seen_r;
    row_min_nxt  = row_min_r;
    row_max_nxt  = row_max_r;
    col_min_nxt  = col_min_r;
    col_max_nxt  = col_max_r;
    if (!old_seen) begin
      if (!any_seen_r) begin
        // first cell ever sets all four bounds
        any_seen_nxt = 1'b1;
        row_min_nxt  = s1_row_r;
        row_max_nxt  = s1_row_r;
        col_min_nxt  = s1_col_r;
        col_max_nxt  = s1_col_r;
      end else begin
        // widen for a new cell
        if (s1_row_r < row_min_r) row_min_nxt = s1_row_r;
        if (s1_row_r > row_max_r) row_max_nxt = s1_row_r;
        if (s1_col_r < col_min_r) col_min_nxt = s1_col_r;
        if (s1_col_r > col_max_r) col_max_nxt = s1_col_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_seen_r <= 1'b0;
      row_min_r  <= '0;
      row_max_r  <= '0;
      col_min_r  <= '0;
      col_max_r  <= '0;
    end else if (s1_fire) begin
      any_seen_r <= any_seen_nxt;
      row_min_r  <= row_min_nxt;
      row_max_r  <= row_max_nxt;
      col_min_r  <= col_min_nxt;
      col_max_r  <= col_max_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  olg_pkg::lo_t    out_lo_r;
  logic            out_first_r;
  olg_pkg::coord_t out_row_min_r, out_row_max_r, out_col_min_r, out_col_max_r;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_lo_r      <= new_lo;
      out_first_r   <= !old_seen;
      out_row_min_r <= row_min_nxt;
      out_row_max_r <= row_max_nxt;
      out_col_min_r <= col_min_nxt;
      out_col_max_r <= col_max_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_logodds = out_lo_r;
  assign out_first_visit = out_first_r;
  assign out_row_min     = out_row_min_r;
  assign out_row_max     = out_row_max_r;
  assign out_col_min     = out_col_min_r;
  assign out_col_max     = out_col_max_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clr_busy_r |-> !in_ready
  ) else $error("request accepted during seen-bit clearing pass");

  a_retire_fills_output: assert property (
    @(posedge clk) disable iff (!rst_n) s1_fire |=> out_valid_r
  ) else $error("retired update did not reach the output register");

  a_box_ordered: assert property (
    @(posedge clk) disable iff (!rst_n)
      any_seen_r |-> (row_min_r <= row_max_r) && (col_min_r <= col_max_r)
  ) else $error("bounding box inverted");

  a_first_visit_marks_seen: assert property (
    @(posedge clk) disable iff (!rst_n) (out_valid_r && out_first_r) |-> any_seen_r
  ) else $error("first visit reported without any seen cell");

endmodule

>>> test/olg_update_checker.sv
// ----------------------------------------------------------------------------
// olg_update_checker: scoreboard for the occupancy log-odds grid update
// Watches the request, result and register ports. Keeps its own copy of the
// grid and the bounding box, works out each updated cell and compares it.
// ----------------------------------------------------------------------------
module olg_update_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  olg_pkg::coord_t                  in_cell_row,
  input  olg_pkg::coord_t                  in_cell_col,
  input  olg_pkg::lo_t                     in_meas_logodds,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  olg_pkg::lo_t                     out_new_logodds,
  input  logic                             out_first_visit,
  input  olg_pkg::coord_t                  out_row_min,
  input  olg_pkg::coord_t                  out_row_max,
  input  olg_pkg::coord_t                  out_col_min,
  input  olg_pkg::coord_t                  out_col_max,
  input  logic                             cfg_we,
  input  logic [olg_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [olg_pkg::LO_BITS-1:0]      cfg_wdata,
  output int                               n_pending,
  output int                               n_fail,
  output int                               n_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    olg_pkg::lo_t    logodds;
    logic            first_visit;
    olg_pkg::coord_t row_min;
    olg_pkg::coord_t row_max;
    olg_pkg::coord_t col_min;
    olg_pkg::coord_t col_max;
  } cell_update_t;

  olg_pkg::lo_t    grid_logodds [olg_pkg::CELL_COUNT];
  bit              grid_seen    [olg_pkg::CELL_COUNT];
  bit              grid_touched;
  olg_pkg::coord_t box_row_min, box_row_max, box_col_min, box_col_max;
  int              lo_floor, lo_ceiling;
  cell_update_t    updates_due [$];
  cell_update_t    want;

  task automatic report_mismatch(string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    n_fail++;
  endtask

  function automatic int clip_edge(int v);
    int r;
    r = v;
    if (v > olg_pkg::EDGE) r = olg_pkg::EDGE;
    else if (v < -olg_pkg::EDGE) r = -olg_pkg::EDGE;
    return r;
  endfunction

  // Fold one measurement into the shadow grid; return what the block must show
  function automatic cell_update_t fold_measurement(olg_pkg::coord_t row, olg_pkg::coord_t col,
                                                    olg_pkg::lo_t meas);
    olg_pkg::addr_t a;
    int             prior;
    int             total;
    cell_update_t   u;
    a     = {row, col};
    prior = grid_seen[a] ? clip_edge(int'(grid_logodds[a])) : 0;
    total = prior + clip_edge(int'(meas));
    if (total < lo_floor) total = lo_floor;
    if (total > lo_ceiling) total = lo_ceiling;
    u.first_visit   = !grid_seen[a];
    grid_logodds[a] = olg_pkg::lo_t'(total);
    grid_seen[a]    = 1'b1;
    if (u.first_visit) begin
      if (!grid_touched) begin
        box_row_min  = row;
        box_row_max  = row;
        box_col_min  = col;
        box_col_max  = col;
        grid_touched = 1'b1;
      end else begin
        if (row < box_row_min) box_row_min = row;
        if (row > box_row_max) box_row_max = row;
        if (col < box_col_min) box_col_min = col;
        if (col > box_col_max) box_col_max = col;
      end
    end
    u.logodds = olg_pkg::lo_t'(total);
    u.row_min = box_row_min;
    u.row_max = box_row_max;
    u.col_min = box_col_min;
    u.col_max = box_col_max;
    return u;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      grid_seen    = '{default: 1'b0};
      grid_touched = 1'b0;
      box_row_min  = '0;
      box_row_max  = '0;
      box_col_min  = '0;
      box_col_max  = '0;
      lo_floor     = -4096;
      lo_ceiling   = 4096;
      updates_due.delete();
    end else begin
      // retire the oldest expectation before queuing this edge's request
      if (out_valid && out_ready) begin
        if (updates_due.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = updates_due.pop_front();
          n_checked++;
          if (out_new_logodds !== want.logodds)
            report_mismatch($sformatf("new_logodds %0d, expected %0d",
                                      out_new_logodds, want.logodds));
          if (out_first_visit !== want.first_visit)
            report_mismatch($sformatf("first_visit %b, expected %b",
                                      out_first_visit, want.first_visit));
          if (out_row_min !== want.row_min)
            report_mismatch($sformatf("row_min %0d, expected %0d", out_row_min, want.row_min));
          if (out_row_max !== want.row_max)
            report_mismatch($sformatf("row_max %0d, expected %0d", out_row_max, want.row_max));
          if (out_col_min !== want.col_min)
            report_mismatch($sformatf("col_min %0d, expected %0d", out_col_min, want.col_min));
          if (out_col_max !== want.col_max)
            report_mismatch($sformatf("col_max %0d, expected %0d", out_col_max, want.col_max));
        end
      end
      if (in_valid && in_ready)
        updates_due.push_back(fold_measurement(in_cell_row, in_cell_col, in_meas_logodds));
      if (cfg_we) begin
        if (cfg_index == olg_pkg::REG_FLOOR) begin
          lo_floor = int'(olg_pkg::lo_t'(cfg_wdata));
        end else if (cfg_index == olg_pkg::REG_CEILING) begin
          lo_ceiling = int'(olg_pkg::ceil_t'(cfg_wdata));
        end
      end
    end
    n_pending = updates_due.size();
  end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the occupancy log-odds grid update
// Drives directed and random cell measurements through several clamp
// settings and handshake pacing modes; the checker beside the block predicts
// and compares every updated cell and hands back its error count.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // handshake pacing of one phase
  typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  localparam int N_PHASES   = 8;
  localparam int PHASE_REQS = 170;

  logic                             clk             = 1'b0;
  logic                             rst_n           = 1'b0;
  logic                             in_valid        = 1'b0;
  logic                             in_ready;
  olg_pkg::coord_t                  in_cell_row     = '0;
  olg_pkg::coord_t                  in_cell_col     = '0;
  olg_pkg::lo_t                     in_meas_logodds = '0;
  logic                             out_valid;
  logic                             out_ready       = 1'b0;
  olg_pkg::lo_t                     out_new_logodds;
  logic                             out_first_visit;
  olg_pkg::coord_t                  out_row_min, out_row_max, out_col_min, out_col_max;
  logic                             cfg_we          = 1'b0;
  logic [olg_pkg::CFG_IDX_BITS-1:0] cfg_index       = '0;
  logic [olg_pkg::LO_BITS-1:0]      cfg_wdata       = '0;

  int n_pending, n_fail, n_checked;
  int stall_pct = 0;   // receiver back-pressure, percent of cycles
  int idle_pct  = 0;   // sender gaps, percent of cycles
  int n_sent    = 0;

  // clamp settings per phase: reset values, the edge range, a closed window,
  // floor above ceiling (ceiling wins), and the full register widths
  int    ph_floor [N_PHASES] = '{-4096, -7073,    0, -1000, -7073, 3000, -8192, -4096};
  int    ph_ceil  [N_PHASES] = '{ 4096,  7073,    0,  7073,     0, 1500,  8191,  4096};
  pace_t ph_pace  [N_PHASES] = '{PACE_NONE, PACE_NONE, PACE_SENDER, PACE_RECEIVER,
                                 PACE_BOTH, PACE_RECEIVER, PACE_SENDER, PACE_BOTH};

  occupancy_logodds_grid_update i_dut (.*);

  olg_update_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Randomize receiver back-pressure at every falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hard limit: the clearing pass after reset plus a slow run, taken many times
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Present one request at a falling edge; hold it until accepted, return at
  // the next falling edge with valid still high
  task automatic send_meas(olg_pkg::coord_t row, olg_pkg::coord_t col, olg_pkg::lo_t meas);
    in_valid        <= 1'b1;
    in_cell_row     <= row;
    in_cell_col     <= col;
    in_meas_logodds <= meas;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
  endtask

  // Leave cfg_we high; the caller lowers it after the last write
  task automatic write_reg(logic [olg_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [olg_pkg::LO_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // Random measurement: mostly strong hits to push cells into the clamps,
  // the rest anywhere in the 14-bit field, including beyond the edge
  function automatic olg_pkg::lo_t pick_meas();
    olg_pkg::lo_t m;
    case ($urandom_range(9)) inside
      [0:3]:   m = olg_pkg::lo_t'($urandom);
      [4:6]:   m = olg_pkg::lo_t'($urandom_range(3000, 500));
      default: m = -olg_pkg::lo_t'($urandom_range(3000, 500));
    endcase
    return m;
  endfunction

  initial begin
    olg_pkg::coord_t hot_row, hot_col, row, col;
    int              wait_cycles;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests at reset clamps, back to back. The first cell sets the
    // whole box away from its reset value; revisits hammer the same cell so
    // the forwarding path and both clamps are hit.
    send_meas(3, -7, 0);
    send_meas(3, -7, 8191);
    send_meas(3, -7, 8191);
    send_meas(3, -7, -8192);
    send_meas(3, -7, 7074);
    send_meas(3, -7, -7074);
    send_meas(5, -3, 7073);
    send_meas(5, -3, -7073);
    send_meas(-128, 127, 1);
    send_meas(127, -128, -1);
    send_meas(-128, -128, 4095);
    send_meas(127, 127, -4097);
    send_meas(127, 127, 7073);
    send_meas(-1, -1, 5461);
    send_meas(0, 0, -2730);
    send_meas(0, 0, 2730);
    send_meas(-128, 127, -8192);
    send_meas(3, -7, 1);
    send_meas(-1, -1, 8191);
    send_meas(-1, -1, 8191);
    drain_results();

    for (int p = 1; p < N_PHASES; p++) begin
      // registers change only with the block idle
      write_reg(olg_pkg::REG_FLOOR, olg_pkg::LO_BITS'(ph_floor[p]));
      write_reg(olg_pkg::REG_CEILING, olg_pkg::LO_BITS'(ph_ceil[p]));
      cfg_we <= 1'b0;

      case (ph_pace[p])
        PACE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
        PACE_SENDER:   begin idle_pct = 64; stall_pct = 0;  end
        PACE_RECEIVER: begin idle_pct = 0;  stall_pct = 64; end
        default:       begin idle_pct = 38; stall_pct = 38; end
      endcase

      // a small hot window per phase gives plenty of revisits and saturation
      hot_row = olg_pkg::coord_t'($urandom);
      hot_col = olg_pkg::coord_t'($urandom);

      for (int k = 0; k < PHASE_REQS; k++) begin
        if ($urandom_range(9) < 7) begin
          row = hot_row + olg_pkg::coord_t'($urandom_range(5));
          col = hot_col + olg_pkg::coord_t'($urandom_range(5));
        end else begin
          row = olg_pkg::coord_t'($urandom);
          col = olg_pkg::coord_t'($urandom);
        end
        // insert sender gaps
        while ($urandom_range(99) < idle_pct) begin
          in_valid <= 1'b0;
          @(negedge clk);
        end
        // now and then let the pipeline run dry mid-stream
        if ($urandom_range(99) == 0) drain_results();
        send_meas(row, col, pick_meas());
      end
      drain_results();
    end

    // final drain with its own bound, then a further wait for stray results
    stall_pct   = 0;
    wait_cycles = 0;
    while (n_pending != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (8) @(negedge clk);
    if (n_pending != 0) $display("ERROR: %0d results never came back", n_pending);

    $display("Covered %0d cell updates across %0d clamp settings and four pacing modes,",
             n_sent, N_PHASES);
    $display("including floor above ceiling and full-width clamps; %0d results compared.",
             n_checked);
    if (n_fail == 0 && n_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
